// File: rtl/hbtd_pkg.sv
// ----------------------------------------------------------------------------
// hbtd_pkg
// Shared types for the telegram receive deframer: result status codes and
// the command / status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package hbtd_pkg;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_SHORT     = 3'd1,
      ST_CRC_ERROR = 3'd2,
      ST_TYPE_ZERO = 3'd3,
      ST_LONG      = 3'd4
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic store;    // byte item accepted
      logic eot;      // accepted item closes the telegram
      logic decode;   // check and decode the stored telegram
      logic read;     // fetch the next payload byte
      logic advance;  // result taken, step to the next payload byte
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic last_result;
   } sts_type;

endpackage

// File: rtl/hbtd_ctrl.sv
// ----------------------------------------------------------------------------
// hbtd_ctrl
// Sequencer: collects bytes, then runs decode and the result run, one
// payload byte fetched from the store per result.
// ----------------------------------------------------------------------------
module hbtd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_end_of_telegram,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hbtd_pkg::cmd_type cmd,
   input  hbtd_pkg::sts_type sts
);

   typedef enum logic [1:0] {
      S_COLLECT,
      S_DECODE,
      S_READ,
      S_SHOW
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;
   logic      store;

   assign store     = req_valid && req_ready_ff;
   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd         = '0;
      cmd.store   = store;
      cmd.eot     = store && req_end_of_telegram;
      cmd.decode  = (state_ff == S_DECODE);
      cmd.read    = (state_ff == S_READ);
      cmd.advance = (state_ff == S_SHOW) && rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_COLLECT;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_COLLECT: begin
               if (store && req_end_of_telegram) begin
                  state_ff     <= S_DECODE;
                  req_ready_ff <= 1'b0;
               end
            end
            S_DECODE: begin
               state_ff <= S_READ;
            end
            S_READ: begin
               state_ff     <= S_SHOW;
               rsp_valid_ff <= 1'b1;
            end
            S_SHOW: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (sts.last_result) begin
                     state_ff     <= S_COLLECT;
                     req_ready_ff <= 1'b1;
                  end else begin
                     state_ff <= S_READ;
                  end
               end
            end
            default: begin
               state_ff     <= S_COLLECT;
               req_ready_ff <= 1'b1;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule

// File: rtl/hbtd_datapath.sv
// ----------------------------------------------------------------------------
// hbtd_datapath
// Byte store, running CRC-8, header capture, decode and result registers.
// ----------------------------------------------------------------------------
module hbtd_datapath #(
   parameter int MAX_TELEGRAM_BYTES = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  hbtd_pkg::cmd_type cmd,
   output hbtd_pkg::sts_type sts,
   input  logic [7:0]        req_rx_byte,
   output logic [2:0]        rsp_status,
   output logic [6:0]        rsp_source,
   output logic [6:0]        rsp_destination,
   output logic              rsp_is_read,
   output logic [7:0]        rsp_offset,
   output logic [15:0]       rsp_type_id,
   output logic [7:0]        rsp_data_byte,
   output logic              rsp_data_valid,
   output logic [4:0]        rsp_msg_length,
   output logic              rsp_bus_mask_bit,
   output logic [15:0]       rsp_crc_error_total,
   output logic              rsp_last
);

   localparam int LW = $clog2(MAX_TELEGRAM_BYTES + 2);  // count incl. overflow value
   localparam int AW = $clog2(MAX_TELEGRAM_BYTES);
   localparam int XW = (LW > 5) ? LW : 5;
   localparam int HDR_BYTES     = 7;
   localparam int PAYLOAD_LIMIT = 27;
   localparam logic [7:0]  CRC_POLY      = 8'h19;
   localparam logic [7:0]  EXT_MARK      = 8'hFF;
   localparam logic [15:0] EXT_TYPE_BASE = 16'd256;

   logic [7:0]    mem [MAX_TELEGRAM_BYTES];
   logic [7:0]    mem_q_ff;

   logic [LW-1:0] count_ff, count_in;
   logic [7:0]    crc_ff, crc_in;
   logic [7:0]    hdr_ff [HDR_BYTES];
   logic [LW-1:0] len_ff;
   logic          crc_ok_ff;
   logic          mask_known_ff, mask_known_in;
   logic          mask_value_ff, mask_value_in;
   logic [15:0]   err_cnt_ff, err_cnt_in;

   hbtd_pkg::status_type status_ff, status_in;
   logic [6:0]    src_ff, src_in;
   logic [6:0]    dst_ff, dst_in;
   logic          rd_ff, rd_in;
   logic [7:0]    off_ff, off_in;
   logic [15:0]   type_ff, type_in;
   logic [4:0]    mlen_ff, mlen_in;
   logic          payload_ff, payload_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [4:0]    remain_ff;

   logic          room;
   logic [LW-1:0] count_inc;

   function automatic logic [7:0] crc_shift(input logic [7:0] x);
      crc_shift = {x[6:0], 1'b0} ^ (x[7] ? CRC_POLY : 8'h00);
   endfunction

   assign room      = (count_ff < LW'(MAX_TELEGRAM_BYTES));
   assign count_inc = room ? (count_ff + LW'(1)) : LW'(MAX_TELEGRAM_BYTES + 1);

   // byte collection
   always_comb begin
      count_in = count_ff;
      crc_in   = crc_ff;
      if (cmd.store) begin
         count_in = count_inc;
         crc_in   = crc_shift(crc_ff) ^ req_rx_byte;
         if (cmd.eot) begin
            count_in = '0;
            crc_in   = '0;
         end
      end
   end

   // decode of the finished telegram
   always_comb begin
      logic [7:0]    gb [HDR_BYTES];
      logic          ext;
      logic [XW-1:0] len_x;
      logic [XW-1:0] mlen_w;
      logic [4:0]    mlen_c;
      logic [15:0]   type_c;
      logic [AW-1:0] start_c;

      for (int k = 0; k < HDR_BYTES; k++) begin
         gb[k] = (LW'(k) < len_ff) ? hdr_ff[k] : 8'h00;
      end
      len_x = XW'(len_ff);
      ext   = (gb[2] == EXT_MARK) && (len_ff >= LW'(6));

      if (!ext) begin
         type_c  = {8'h00, gb[2]};
         start_c = AW'(4);
         mlen_w  = (len_x >= XW'(5)) ? (len_x - XW'(5)) : '0;
      end else if (gb[1][7]) begin
         type_c  = {gb[5], gb[6]} + EXT_TYPE_BASE;
         start_c = AW'(4);
         mlen_w  = XW'(1);
      end else begin
         type_c  = {gb[4], gb[5]} + EXT_TYPE_BASE;
         start_c = AW'(6);
         mlen_w  = (len_x >= XW'(7)) ? (len_x - XW'(7)) : '0;
      end
      mlen_c = (mlen_w > XW'(PAYLOAD_LIMIT)) ? 5'(PAYLOAD_LIMIT) : mlen_w[4:0];

      mask_known_in = mask_known_ff;
      mask_value_in = mask_value_ff;
      err_cnt_in    = err_cnt_ff;
      status_in     = hbtd_pkg::ST_OK;
      src_in        = '0;
      dst_in        = '0;
      rd_in         = 1'b0;
      off_in        = '0;
      type_in       = '0;
      mlen_in       = '0;
      payload_in    = 1'b0;
      ptr_in        = start_c;

      if (len_ff > LW'(MAX_TELEGRAM_BYTES)) begin
         status_in = hbtd_pkg::ST_LONG;
      end else if (len_ff < LW'(2)) begin
         status_in = hbtd_pkg::ST_SHORT;
      end else if (!crc_ok_ff) begin
         status_in = hbtd_pkg::ST_CRC_ERROR;
         if (err_cnt_ff != 16'hFFFF) begin
            err_cnt_in = err_cnt_ff + 16'd1;
         end
      end else begin
         if (!mask_known_ff) begin
            mask_known_in = 1'b1;
            mask_value_in = hdr_ff[0][7];
         end
         src_in  = gb[0][6:0];
         dst_in  = gb[1][6:0];
         rd_in   = gb[1][7];
         off_in  = gb[3];
         mlen_in = mlen_c;
         if (type_c == 16'h0000) begin
            status_in = hbtd_pkg::ST_TYPE_ZERO;
         end else begin
            type_in    = type_c;
            payload_in = (mlen_c != 5'd0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         crc_ff        <= '0;
         mask_known_ff <= 1'b0;
         mask_value_ff <= 1'b0;
         err_cnt_ff    <= '0;
      end else begin
         count_ff <= count_in;
         crc_ff   <= crc_in;
         if (cmd.decode) begin
            mask_known_ff <= mask_known_in;
            mask_value_ff <= mask_value_in;
            err_cnt_ff    <= err_cnt_in;
         end
      end
   end

   // byte store and header copy
   always_ff @(posedge clock) begin
      if (cmd.store && room) begin
         mem[count_ff[AW-1:0]] <= req_rx_byte;
      end
      if (cmd.store && (count_ff < LW'(HDR_BYTES))) begin
         hdr_ff[count_ff[2:0]] <= req_rx_byte;
      end
      if (cmd.eot) begin
         len_ff    <= count_inc;
         crc_ok_ff <= (req_rx_byte == crc_ff);  // CRC over all bytes before this one
      end
      if (cmd.read) begin
         mem_q_ff <= mem[ptr_ff];
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      if (cmd.decode) begin
         status_ff  <= status_in;
         src_ff     <= src_in;
         dst_ff     <= dst_in;
         rd_ff      <= rd_in;
         off_ff     <= off_in;
         type_ff    <= type_in;
         mlen_ff    <= mlen_in;
         payload_ff <= payload_in;
         ptr_ff     <= ptr_in;
         remain_ff  <= mlen_in;
      end else if (cmd.advance) begin
         ptr_ff    <= ptr_ff + AW'(1);
         remain_ff <= remain_ff - 5'd1;
      end
   end

   assign sts.last_result = !payload_ff || (remain_ff == 5'd1);

   assign rsp_status          = status_ff;
   assign rsp_source          = src_ff;
   assign rsp_destination     = dst_ff;
   assign rsp_is_read         = rd_ff;
   assign rsp_offset          = off_ff;
   assign rsp_type_id         = type_ff;
   assign rsp_data_byte       = payload_ff ? mem_q_ff : 8'h00;
   assign rsp_data_valid      = payload_ff;
   assign rsp_msg_length      = mlen_ff;
   assign rsp_bus_mask_bit    = mask_value_ff;
   assign rsp_crc_error_total = err_cnt_ff;
   assign rsp_last            = sts.last_result;

endmodule

// File: rtl/heating_bus_telegram_rx_deframer_core.sv
// ----------------------------------------------------------------------------
// heating_bus_telegram_rx_deframer_core
// Telegram receive deframer: CRC-8 check, header decode, payload run.
// ----------------------------------------------------------------------------
// Bytes without end mark can be offered back to back while req_ready is high.
// The end-marked byte is followed by a decode state, and each result needs
// a store read state before it is shown, so the input stays closed from the
// end-marked byte until the last result is taken, including any output stall.
// Synchronous active-high reset clears the sequencer, byte count, CRC, mask
// and error counter; the byte store is not cleared.
module heating_bus_telegram_rx_deframer_core #(
   parameter int MAX_TELEGRAM_BYTES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_end_of_telegram,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [6:0]  rsp_source,
   output logic [6:0]  rsp_destination,
   output logic        rsp_is_read,
   output logic [7:0]  rsp_offset,
   output logic [15:0] rsp_type_id,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_data_valid,
   output logic [4:0]  rsp_msg_length,
   output logic        rsp_bus_mask_bit,
   output logic [15:0] rsp_crc_error_total,
   output logic        rsp_last
);

   hbtd_pkg::cmd_type cmd;
   hbtd_pkg::sts_type sts;

   hbtd_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_end_of_telegram (req_end_of_telegram),
      .req_ready           (req_ready),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .cmd                 (cmd),
      .sts                 (sts)
   );

   hbtd_datapath #(
      .MAX_TELEGRAM_BYTES (MAX_TELEGRAM_BYTES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_rx_byte         (req_rx_byte),
      .rsp_status          (rsp_status),
      .rsp_source          (rsp_source),
      .rsp_destination     (rsp_destination),
      .rsp_is_read         (rsp_is_read),
      .rsp_offset          (rsp_offset),
      .rsp_type_id         (rsp_type_id),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_data_valid      (rsp_data_valid),
      .rsp_msg_length      (rsp_msg_length),
      .rsp_bus_mask_bit    (rsp_bus_mask_bit),
      .rsp_crc_error_total (rsp_crc_error_total),
      .rsp_last            (rsp_last)
   );

`ifndef NO_ASSERTIONS
   a_no_overlap : assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while a result is pending");

   a_error_single : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != hbtd_pkg::ST_OK) |-> (rsp_last && !rsp_data_valid))
      else $error("error result not a single last item");

   a_payload_len : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data_valid) |-> (rsp_msg_length != 5'd0))
      else $error("payload item with zero length");

   a_eot_stops_input : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_end_of_telegram) |=> !req_ready)
      else $error("input still open after end of telegram");
`endif

endmodule
